// ===== src/fragment_reassembly_tracker_core_macros.svh =====
// assertion macros shared by the fragment reassembly tracker rtl
`ifndef FRAGMENT_REASSEMBLY_TRACKER_CORE_MACROS_SVH
`define FRAGMENT_REASSEMBLY_TRACKER_CORE_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define FRT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FRT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/frt_pkg.sv =====
// types, constants and sizes for the fragment reassembly tracker
package frt_pkg;

  localparam int SLOT_W      = 4;
  localparam int FRAME_SLOTS = 1 << SLOT_W;
  localparam int MAX_PACKETS = 64;
  localparam int MAX_PAYLOAD = 1500;

  localparam int ID_W   = 32;
  localparam int PAY_W  = 11;
  localparam int SUM_W  = 17;
  localparam int CNT_W  = $clog2(MAX_PACKETS + 1);
  localparam int IDX_W  = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
  localparam int MAP_W  = MAX_PACKETS;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef enum logic [1:0] {
    ST_NEW       = 2'd0,
    ST_DUP       = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_TOO_LARGE = 2'd3
  } status_e;

  typedef struct packed {
    logic             valid;
    logic [ID_W-1:0]  tag;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] count;
    logic [MAP_W-1:0] seen_map;
    logic [SUM_W-1:0] byte_sum;
  } slot_t;

  typedef struct packed {
    logic [ID_W-1:0]  frame_id;
    logic [ID_W-1:0]  packet_index;
    logic [ID_W-1:0]  total_packets;
    logic [PAY_W-1:0] payload_bytes;
  } hdr_t;

  typedef struct packed {
    status_e          status;
    logic             restarted;
    logic             evicted;
    logic             frame_done;
    logic [ID_W-1:0]  done_frame_id;
    logic [SUM_W-1:0] frame_bytes;
  } result_t;

endpackage

// ===== src/frt_slot_table.sv =====
// direct-mapped frame context table: one read port, one write port
module frt_slot_table import frt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SLOT_W-1:0] rd_idx_i,
  output slot_t             rd_entry_o,
  input  logic              wr_en_i,
  input  logic [SLOT_W-1:0] wr_idx_i,
  input  slot_t             wr_entry_i
);

  logic [FRAME_SLOTS-1:0] valid_q;
  logic [ID_W-1:0]        tag_q   [FRAME_SLOTS];
  logic [CNT_W-1:0]       total_q [FRAME_SLOTS];
  logic [CNT_W-1:0]       count_q [FRAME_SLOTS];
  logic [MAP_W-1:0]       map_q   [FRAME_SLOTS];
  logic [SUM_W-1:0]       sum_q   [FRAME_SLOTS];

  // only the valid bits are cleared, the rest is read behind a valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_idx_i] <= wr_entry_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      tag_q[wr_idx_i]   <= wr_entry_i.tag;
      total_q[wr_idx_i] <= wr_entry_i.total;
      count_q[wr_idx_i] <= wr_entry_i.count;
      map_q[wr_idx_i]   <= wr_entry_i.seen_map;
      sum_q[wr_idx_i]   <= wr_entry_i.byte_sum;
    end
  end

  always_comb begin
    rd_entry_o.valid    = valid_q[rd_idx_i];
    rd_entry_o.tag      = tag_q[rd_idx_i];
    rd_entry_o.total    = total_q[rd_idx_i];
    rd_entry_o.count    = count_q[rd_idx_i];
    rd_entry_o.seen_map = map_q[rd_idx_i];
    rd_entry_o.byte_sum = sum_q[rd_idx_i];
  end

endmodule

// ===== src/frt_update.sv =====
// per-header context update and result formation
module frt_update import frt_pkg::*; (
  input  hdr_t    hdr_i,
  input  slot_t   cur_i,
  output logic    wr_en_o,
  output slot_t   nxt_o,
  output result_t res_o
);

  logic             bad_index;
  logic             too_large;
  logic [CNT_W-1:0] tot_n;
  logic [IDX_W-1:0] bit_idx;
  logic             miss;
  logic             tag_diff;
  logic             tot_diff;
  logic             seen;
  logic [PAY_W-1:0] pay_clamp;
  logic [SUM_W:0]   sum_wide;
  slot_t            base;

  always_comb begin
    bad_index = hdr_i.packet_index >= hdr_i.total_packets;
    too_large = hdr_i.total_packets > ID_W'(MAX_PACKETS);
    tot_n     = hdr_i.total_packets[CNT_W-1:0];
    bit_idx   = hdr_i.packet_index[IDX_W-1:0];

    miss     = !cur_i.valid;
    tag_diff = cur_i.valid && (cur_i.tag != hdr_i.frame_id);
    tot_diff = cur_i.valid && !tag_diff && (cur_i.total != tot_n);

    // open a fresh context on a free slot, another frame, or a changed total
    if (miss || tag_diff || tot_diff) begin
      base.valid    = 1'b1;
      base.tag      = hdr_i.frame_id;
      base.total    = tot_n;
      base.count    = '0;
      base.seen_map = '0;
      base.byte_sum = '0;
    end else begin
      base = cur_i;
    end

    seen = base.seen_map[bit_idx];

    if (32'(hdr_i.payload_bytes) > 32'(MAX_PAYLOAD)) begin
      pay_clamp = PAY_W'(MAX_PAYLOAD);
    end else begin
      pay_clamp = hdr_i.payload_bytes;
    end
    sum_wide = {1'b0, base.byte_sum} + (SUM_W + 1)'(pay_clamp);

    nxt_o = base;
    if (!seen) begin
      nxt_o.seen_map[bit_idx] = 1'b1;
      nxt_o.count             = base.count + CNT_W'(1);
      nxt_o.byte_sum          = (sum_wide > {1'b0, SUM_MAX}) ? SUM_MAX
                                                             : sum_wide[SUM_W-1:0];
      if (nxt_o.count == base.total) begin
        nxt_o.valid = 1'b0;
      end
    end

    wr_en_o = !bad_index && !too_large;

    res_o.restarted     = 1'b0;
    res_o.evicted       = 1'b0;
    res_o.frame_done    = 1'b0;
    res_o.done_frame_id = '0;
    res_o.frame_bytes   = '0;
    if (bad_index) begin
      res_o.status = ST_BAD_INDEX;
    end else if (too_large) begin
      res_o.status = ST_TOO_LARGE;
    end else begin
      res_o.restarted = tot_diff;
      res_o.evicted   = tag_diff;
      if (seen) begin
        res_o.status = ST_DUP;
      end else begin
        res_o.status = ST_NEW;
        if (!nxt_o.valid) begin
          res_o.frame_done    = 1'b1;
          res_o.done_frame_id = hdr_i.frame_id;
          res_o.frame_bytes   = nxt_o.byte_sum;
        end
      end
    end
  end

endmodule

// ===== src/fragment_reassembly_tracker_core.sv =====
// a header beat is registered in the input stage, then its result moves into the result register
// throughput: one header beat per cycle while the result side is not stalled, also back to back
//   on the same slot, since the slot table is read and written in the cycle the held header advances
// the rate is set by the one combinational update between input and result registers
// reset: asynchronous active-low, clears all slot valid bits and both stage valids
`include "fragment_reassembly_tracker_core_macros.svh"

module fragment_reassembly_tracker_core import frt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ID_W-1:0]  frame_id_i,
  input  logic [ID_W-1:0]  packet_index_i,
  input  logic [ID_W-1:0]  total_packets_i,
  input  logic [PAY_W-1:0] payload_bytes_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       status_o,
  output logic             restarted_o,
  output logic             evicted_o,
  output logic             frame_done_o,
  output logic [ID_W-1:0]  done_frame_id_o,
  output logic [SUM_W-1:0] frame_bytes_o
);

  // input register stage
  logic    in_vld_q, in_vld_d;
  hdr_t    hdr_q;
  // result register stage
  logic    out_vld_q, out_vld_d;
  result_t res_q;

  logic    in_take;   // header beat accepted this cycle
  logic    advance;   // input stage moves into the result register

  slot_t             cur_entry;
  slot_t             nxt_entry;
  logic              tbl_wr;
  result_t           res_d;
  logic [SLOT_W-1:0] slot_idx;

  // slot index is the low bits of the frame id (table depth is a power of two)
  assign slot_idx = hdr_q.frame_id[SLOT_W-1:0];

  // the held header advances whenever the result register is free or draining
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      hdr_q.frame_id      <= frame_id_i;
      hdr_q.packet_index  <= packet_index_i;
      hdr_q.total_packets <= total_packets_i;
      hdr_q.payload_bytes <= payload_bytes_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  // context table, written in the same cycle the header is resolved
  frt_slot_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (slot_idx),
    .rd_entry_o (cur_entry),
    .wr_en_i    (advance && tbl_wr),
    .wr_idx_i   (slot_idx),
    .wr_entry_i (nxt_entry)
  );

  // checks, eviction, restart, duplicate detection and completion
  frt_update u_update (
    .hdr_i   (hdr_q),
    .cur_i   (cur_entry),
    .wr_en_o (tbl_wr),
    .nxt_o   (nxt_entry),
    .res_o   (res_d)
  );

  assign out_valid_o     = out_vld_q;
  assign status_o        = res_q.status;
  assign restarted_o     = res_q.restarted;
  assign evicted_o       = res_q.evicted;
  assign frame_done_o    = res_q.frame_done;
  assign done_frame_id_o = res_q.done_frame_id;
  assign frame_bytes_o   = res_q.frame_bytes;

  // a completed frame always comes from a newly stored packet
  `FRT_ASSERT_IMP(a_done_is_new, out_vld_q && res_q.frame_done, res_q.status == ST_NEW, "frame done without new packet")
  // rejected headers raise no flags
  `FRT_ASSERT_IMP(a_reject_quiet, out_vld_q && (res_q.status == ST_BAD_INDEX || res_q.status == ST_TOO_LARGE), !res_q.restarted && !res_q.evicted && !res_q.frame_done, "flag set on rejected header")
  // done id and byte count are zero unless the frame completed
  `FRT_ASSERT_IMP(a_idle_fields_zero, out_vld_q && !res_q.frame_done, res_q.done_frame_id == '0 && res_q.frame_bytes == '0, "done fields nonzero without completion")
  // the input side only stalls while a result is held back downstream
  `FRT_ASSERT_IMP(a_stall_cause, in_stall_o, out_vld_q && out_stall_i && in_vld_q, "input stalled without backpressure")
  // an advancing beat always lands in the result register
  `FRT_ASSERT_NXT(a_advance_lands, advance, out_vld_q, "advanced beat lost")

endmodule

// ===== tb/frt_result_checker.sv =====
// result checker for the fragment reassembly tracker: tracks frame contexts and compares results
module frt_result_checker import frt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [ID_W-1:0]  frame_id_i,
  input  logic [ID_W-1:0]  packet_index_i,
  input  logic [ID_W-1:0]  total_packets_i,
  input  logic [PAY_W-1:0] payload_bytes_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [1:0]       status_i,
  input  logic             restarted_i,
  input  logic             evicted_i,
  input  logic             frame_done_i,
  input  logic [ID_W-1:0]  done_frame_id_i,
  input  logic [SUM_W-1:0] frame_bytes_i,
  output int               fail_cnt_o,
  output int               pending_o,
  output int               results_o,
  output int               frames_done_o,
  output int               evictions_o,
  output int               restarts_o
);

  // shadow copy of the slot table
  logic             ctx_valid [FRAME_SLOTS];
  logic [ID_W-1:0]  ctx_tag   [FRAME_SLOTS];
  int unsigned      ctx_total [FRAME_SLOTS];
  int unsigned      ctx_count [FRAME_SLOTS];
  logic [MAP_W-1:0] ctx_seen  [FRAME_SLOTS];
  int unsigned      ctx_bytes [FRAME_SLOTS];

  result_t expected_results [$];

  task automatic report_mismatch(input string what, input logic [ID_W-1:0] got,
                                 input logic [ID_W-1:0] want_v);
    $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
             results_o, what, got, want_v);
    fail_cnt_o = fail_cnt_o + 1;
  endtask

  function automatic result_t track_header(input logic [ID_W-1:0] fid,
                                           input logic [ID_W-1:0] idx,
                                           input logic [ID_W-1:0] tot,
                                           input logic [PAY_W-1:0] pay);
    result_t          r;
    logic [SLOT_W-1:0] s;
    logic [MAP_W-1:0] idx_mask;
    int unsigned      len;
    r = '0;
    s = fid[SLOT_W-1:0];
    if (idx >= tot) begin
      r.status = ST_BAD_INDEX;
    end else if (tot > MAX_PACKETS) begin
      r.status = ST_TOO_LARGE;
    end else begin
      if (!ctx_valid[s] || ctx_tag[s] != fid || ctx_total[s] != tot) begin
        r.evicted   = ctx_valid[s] && (ctx_tag[s] != fid);
        r.restarted = ctx_valid[s] && (ctx_tag[s] == fid) && (ctx_total[s] != tot);
        ctx_valid[s] = 1'b1;
        ctx_tag[s]   = fid;
        ctx_total[s] = tot;
        ctx_count[s] = 0;
        ctx_seen[s]  = '0;
        ctx_bytes[s] = 0;
      end
      idx_mask = '0;
      idx_mask[idx[IDX_W-1:0]] = 1'b1;
      if ((ctx_seen[s] & idx_mask) == '0) begin
        len = (pay > MAX_PAYLOAD) ? MAX_PAYLOAD : pay;
        ctx_seen[s]  = ctx_seen[s] | idx_mask;
        ctx_count[s] = ctx_count[s] + 1;
        ctx_bytes[s] = ctx_bytes[s] + len;
        if (ctx_bytes[s] > SUM_MAX) ctx_bytes[s] = SUM_MAX;
        r.status = ST_NEW;
        if (ctx_count[s] == ctx_total[s]) begin
          r.frame_done    = 1'b1;
          r.done_frame_id = fid;
          r.frame_bytes   = ctx_bytes[s][SUM_W-1:0];
          ctx_valid[s]    = 1'b0;
        end
      end else begin
        r.status = ST_DUP;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    result_t fresh;
    if (!rst_ni) begin
      for (int i = 0; i < FRAME_SLOTS; i++) ctx_valid[i] = 1'b0;
      expected_results.delete();
      fail_cnt_o    = 0;
      results_o     = 0;
      frames_done_o = 0;
      evictions_o   = 0;
      restarts_o    = 0;
    end else begin
      // result side first: it can only belong to an older header
      if (out_valid_i && !out_stall_i) begin
        results_o = results_o + 1;
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing pending, status", status_i, '0);
        end else begin
          want = expected_results.pop_front();
          if (status_i !== want.status)
            report_mismatch("status", status_i, want.status);
          if (restarted_i !== want.restarted)
            report_mismatch("restarted", restarted_i, want.restarted);
          if (evicted_i !== want.evicted)
            report_mismatch("evicted", evicted_i, want.evicted);
          if (frame_done_i !== want.frame_done)
            report_mismatch("frame_done", frame_done_i, want.frame_done);
          if (done_frame_id_i !== want.done_frame_id)
            report_mismatch("done_frame_id", done_frame_id_i, want.done_frame_id);
          if (frame_bytes_i !== want.frame_bytes)
            report_mismatch("frame_bytes", frame_bytes_i, want.frame_bytes);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        fresh = track_header(frame_id_i, packet_index_i, total_packets_i, payload_bytes_i);
        frames_done_o = frames_done_o + fresh.frame_done;
        evictions_o   = evictions_o + fresh.evicted;
        restarts_o    = restarts_o + fresh.restarted;
        expected_results.push_back(fresh);
      end
    end
    pending_o = expected_results.size();
  end

endmodule

// ===== tb/fragment_reassembly_tracker_core_tb.sv =====
// testbench top for the fragment reassembly tracker: header stimulus, receiver stalls, verdict
module fragment_reassembly_tracker_core_tb;
  import frt_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [ID_W-1:0]  frame_id;
  logic [ID_W-1:0]  packet_index;
  logic [ID_W-1:0]  total_packets;
  logic [PAY_W-1:0] payload_bytes;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       status;
  logic             restarted;
  logic             evicted;
  logic             frame_done;
  logic [ID_W-1:0]  done_frame_id;
  logic [SUM_W-1:0] frame_bytes;

  int fail_cnt;
  int pending;
  int n_results;
  int n_done;
  int n_evict;
  int n_restart;

  int burst_left = 0;
  int sent_cnt   = 0;

  // receiver stall pattern state
  int stall_mode  = 0;
  int stall_phase = 0;
  int stall_run   = 0;

  fragment_reassembly_tracker_core i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .frame_id_i      (frame_id),
    .packet_index_i  (packet_index),
    .total_packets_i (total_packets),
    .payload_bytes_i (payload_bytes),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .status_o        (status),
    .restarted_o     (restarted),
    .evicted_o       (evicted),
    .frame_done_o    (frame_done),
    .done_frame_id_o (done_frame_id),
    .frame_bytes_o   (frame_bytes)
  );

  frt_result_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .frame_id_i      (frame_id),
    .packet_index_i  (packet_index),
    .total_packets_i (total_packets),
    .payload_bytes_i (payload_bytes),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .status_i        (status),
    .restarted_i     (restarted),
    .evicted_i       (evicted),
    .frame_done_i    (frame_done),
    .done_frame_id_i (done_frame_id),
    .frame_bytes_i   (frame_bytes),
    .fail_cnt_o      (fail_cnt),
    .pending_o       (pending),
    .results_o       (n_results),
    .frames_done_o   (n_done),
    .evictions_o     (n_evict),
    .restarts_o      (n_restart)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver: phases of no stall, random stall, long stall runs and toggling
  always @(posedge clk) begin
    if (stall_phase == 0) begin
      stall_mode  <= $urandom_range(0, 3);
      stall_phase <= $urandom_range(20, 200);
    end else begin
      stall_phase <= stall_phase - 1;
    end
    case (stall_mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 99) < 30);
      end
      2: begin
        if (stall_run == 0) begin
          out_stall <= ~out_stall;
          stall_run <= $urandom_range(1, 12);
        end else begin
          stall_run <= stall_run - 1;
        end
      end
      default: begin
        out_stall <= ~out_stall;
      end
    endcase
  end

  // one header beat, with a random gap whenever a burst has run out
  task automatic send_hdr(input logic [ID_W-1:0] fid, input logic [ID_W-1:0] idx,
                          input logic [ID_W-1:0] tot, input logic [PAY_W-1:0] pay);
    int gap;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    in_valid      <= 1'b1;
    frame_id      <= fid;
    packet_index  <= idx;
    total_packets <= tot;
    payload_bytes <= pay;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left = burst_left - 1;
    sent_cnt   = sent_cnt + 1;
  endtask

  // mostly short frames, a few up to the full bitmap
  function automatic int pick_total();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 6);
    if (r < 95) return $urandom_range(7, 40);
    return $urandom_range(41, MAX_PACKETS);
  endfunction

  // lengths in range, above the clamp, zero, and raw 11-bit values
  function automatic logic [PAY_W-1:0] pick_payload();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return PAY_W'($urandom_range(1, MAX_PAYLOAD));
    if (r < 88) return PAY_W'($urandom_range(MAX_PAYLOAD + 1, 2047));
    if (r < 94) return '0;
    return PAY_W'($urandom());
  endfunction

  // index below tot whose seen bit equals want, scanning from a random start
  function automatic int find_index(input logic [MAP_W-1:0] map, input int tot,
                                    input logic want);
    int start;
    int p;
    start = $urandom_range(0, tot - 1);
    for (int j = 0; j < tot; j++) begin
      p = (start + j) % tot;
      if (map[p] == want) return p;
    end
    return -1;
  endfunction

  // frames in flight on the generator side, each on a slot group of its own
  logic [ID_W-1:0]  of_fid  [4];
  int               of_tot  [4];
  int               of_left [4];
  logic [MAP_W-1:0] of_seen [4];

  initial begin
    int n;
    int roll;
    int k;
    int p;
    int t;
    logic [ID_W-1:0] t32;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    frame_id      = '0;
    packet_index  = '0;
    total_packets = '0;
    payload_bytes = '0;
    for (int i = 0; i < 4; i++) begin
      of_fid[i]  = '0;
      of_tot[i]  = 0;
      of_left[i] = 0;
      of_seen[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: rejects at the field extremes
    send_hdr(32'd5, 32'd0, 32'd0, 11'd100);                    // zero total
    send_hdr(32'd5, 32'd7, 32'd7, 11'd100);                    // index equals total
    send_hdr(32'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd1);
    send_hdr(32'd5, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 11'd2047);   // too large, index fine
    send_hdr(32'd5, 32'd0, 32'd65, 11'd1);                     // one above the bitmap
    send_hdr(32'd7, 32'd64, 32'd64, 11'd5);
    send_hdr(32'd7, 32'd0, 32'h8000_0000, 11'd5);
    // single packet frame at the top frame id
    send_hdr(32'hFFFF_FFFF, 32'd0, 32'd1, 11'd1500);
    // clamp, duplicate keeps the first length, zero payload completes
    send_hdr(32'd0, 32'd1, 32'd2, 11'd2047);
    send_hdr(32'd0, 32'd1, 32'd2, 11'd9);
    send_hdr(32'd0, 32'd0, 32'd2, 11'd0);
    // restart on a changed total, then eviction by another id on the same slot
    send_hdr(32'd3, 32'd0, 32'd4, 11'd10);
    send_hdr(32'd3, 32'd2, 32'd3, 11'd20);
    send_hdr(32'd19, 32'd0, 32'd2, 11'd30);
    send_hdr(32'd19, 32'd1, 32'd2, 11'd40);
    // full-width bitmap, top index, duplicate, then evict with an instant completion
    send_hdr(32'h8000_0010, 32'd63, 32'd64, 11'd1500);
    send_hdr(32'h8000_0010, 32'd0, 32'd64, 11'd1);
    send_hdr(32'h8000_0010, 32'd63, 32'd64, 11'd3);
    send_hdr(32'h0000_0020, 32'd0, 32'd1, 11'd1);

    // random: mostly well-formed frames interleaved, with duplicates, restarts and noise
    for (n = 0; n < 1100; n++) begin
      roll = $urandom_range(0, 99);
      k    = $urandom_range(0, 3);
      if (roll < 84) begin
        if (of_left[k] == 0) begin
          of_fid[k]  = ($urandom() & 32'hFFFF_FFF0) | ID_W'(k * 4 + $urandom_range(0, 3));
          of_tot[k]  = pick_total();
          of_seen[k] = '0;
          of_left[k] = of_tot[k];
        end else if (roll >= 80) begin
          // same frame, different total
          t = pick_total();
          if (t == of_tot[k]) t = t % MAX_PACKETS + 1;
          of_tot[k]  = t;
          of_seen[k] = '0;
          of_left[k] = t;
        end
        p = -1;
        if (roll >= 72 && roll < 80) p = find_index(of_seen[k], of_tot[k], 1'b1);
        if (p < 0) p = find_index(of_seen[k], of_tot[k], 1'b0);
        send_hdr(of_fid[k], ID_W'(p), ID_W'(of_tot[k]), pick_payload());
        if (!of_seen[k][p]) begin
          of_seen[k][p] = 1'b1;
          of_left[k]    = of_left[k] - 1;
        end
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            send_hdr($urandom(), $urandom(), $urandom(), pick_payload());
          end
          1: begin
            // total too large with a legal index, full-width values
            t32 = $urandom();
            if (t32 <= MAX_PACKETS) t32 = t32 + 65;
            send_hdr($urandom(), $urandom_range(0, t32 - 1), t32, pick_payload());
          end
          2: begin
            t = $urandom_range(0, MAX_PACKETS);
            send_hdr($urandom(), ID_W'(t + $urandom_range(0, 3)), ID_W'(t), pick_payload());
          end
          default: begin
            // legal header for a stray frame, may evict one in flight
            t = pick_total();
            send_hdr($urandom(), ID_W'($urandom_range(0, t - 1)), ID_W'(t), pick_payload());
          end
        endcase
      end
    end
    in_valid <= 1'b0;

    // drain, then leave room for anything stray
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d header beats, %0d result beats checked", sent_cnt, n_results);
    $display("frames completed %0d, evictions %0d, restarts %0d, mismatches %0d",
             n_done, n_evict, n_restart, fail_cnt);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
